// ----- design/bfng_pkg.sv -----
// bfng_pkg: shared constants, register indexes, walk modes and the
// command and status structs between the controller and the datapath
// no dependencies
package bfng_pkg;

    localparam int VERT_BITS       = 8;
    localparam int RAW_WEIGHT_BITS = 16;
    localparam int COST_BITS       = 24;
    localparam int WIDE_WEIGHT     = 33;
    localparam int EDGE_BITS       = 2 * VERT_BITS + RAW_WEIGHT_BITS;
    localparam int VERT_SLOTS      = 1 << VERT_BITS;
    localparam int QCOUNT_BITS     = VERT_BITS + 1;

    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET       = 2'd2;

    localparam logic [VERT_BITS-1:0] RESET_VERTEX_COUNT = 8'd255;
    localparam logic [VERT_BITS-1:0] RESET_SOURCE       = 8'd1;
    localparam logic [VERT_BITS-1:0] RESET_TARGET       = 8'd1;

    // what one walk over the edge store does with each edge
    localparam logic [1:0] MODE_RELAX  = 2'd0;
    localparam logic [1:0] MODE_DETECT = 2'd1;
    localparam logic [1:0] MODE_SPREAD = 2'd2;

    typedef struct packed {
        logic       load_en;
        logic       init;
        logic       fetch;
        logic       dist_rd;
        logic       cand;
        logic       cmp;
        logic       round_next;
        logic       walk_restart;
        logic       q_rd;
        logic       q_take;
        logic       t_rd;
        logic       emit;
        logic [1:0] mode;
    } t_cmd;

    typedef struct packed {
        logic start;
        logic clr_last;
        logic walk_end;
        logic changed;
        logic more_rounds;
        logic vc_gt1;
        logic q_empty;
        logic out_free;
    } t_status;

endpackage

// ----- design/bfng_if.sv -----
// bfng_edge_if and bfng_res_if: valid/ready channels for edges and results
// depends on nothing
interface bfng_edge_if;
    logic        valid;
    logic        ready;
    logic [7:0]  from_vertex;
    logic [7:0]  to_vertex;
    logic [15:0] edge_weight;
    logic        last_edge;

    modport source (output valid, from_vertex, to_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, from_vertex, to_vertex, edge_weight, last_edge,
                  output ready);
endinterface

interface bfng_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] path_cost;
    logic               no_answer;
    logic               edges_dropped;

    modport source (output valid, path_cost, no_answer, edges_dropped, input ready);
    modport sink (input valid, path_cost, no_answer, edges_dropped, output ready);
endinterface

// ----- design/bellman_ford_negative_cycle_guard.sv -----
// bellman_ford_negative_cycle_guard: top level, joins the sequencer and the datapath
// depends on bfng_pkg, bfng_if, bfng_ctrl and bfng_dp
//
// Edges transfer in one per cycle and go into the edge store (MAX_EDGES deep);
// edges past capacity are dropped and flagged in the result. The edge that
// carries last_edge starts a solve and the input stalls until the solve is
// over: a clearing pass over the distance and mark rams, then
// single-source shortest paths from source_vertex by up to
// vertex_count-1 relaxation rounds (early stop when a round changes nothing),
// then a detection walk that marks vertices still relaxable, then a spread of
// the marks along the edges, one walk per marked vertex. Every walk visits the
// stored edges one after another through the edge ram and a distance ram
// pair, each edge going through the fetch, edge read, distance read and
// compare states in turn. One result transfers per graph: target cost,
// no-answer flag and drop flag. The result sits in an output register, so
// the next graph's edges can load while it waits. Reach and mark bits live
// in rams beside the distances and are cleared by the pass at solve start.
// Configuration is to be written by the user only while idle; the block does not enforce it.
module bellman_ford_negative_cycle_guard #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [bfng_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [bfng_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // edge input and result output channels
    bfng_edge_if.sink                          i_edge,
    bfng_res_if.source                         o_res
);
    bfng_pkg::t_cmd    cmd;
    bfng_pkg::t_status st;

    // sequencer: clearing pass, walk modes, round loop, queue drain
    bfng_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // storage, arithmetic and the result register
    bfng_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (i_edge),
        .o_res      (o_res),
        .i_cmd      (cmd),
        .o_st       (st)
    );
endmodule

// ----- design/bfng_ram.sv -----
// bfng_ram: generic single write, single read ram with registered read
// depends on nothing
module bfng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bfng_ctrl.sv -----
// bfng_ctrl: sequencer for loading, relaxation rounds, detection and spreading
// depends on bfng_pkg
module bfng_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfng_pkg::t_status i_st,
    output bfng_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_EDGE  = 4'd3;
    localparam logic [3:0] S_DIST  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_QRD   = 4'd6;
    localparam logic [3:0] S_QTAKE = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.mode = r_phase;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_en = 1'b1;
                if (i_st.start) n_state = S_INIT;
            end
            S_INIT: begin
                // clearing pass over the distance and mark rams
                o_cmd.init = 1'b1;
                if (i_st.clr_last) begin
                    n_phase = i_st.vc_gt1 ? bfng_pkg::MODE_RELAX : bfng_pkg::MODE_DETECT;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!i_st.walk_end) begin
                    o_cmd.fetch = 1'b1;
                    n_state = S_EDGE;
                end else if (r_phase == bfng_pkg::MODE_RELAX) begin
                    if (i_st.changed && i_st.more_rounds) begin
                        o_cmd.round_next = 1'b1;
                    end else begin
                        o_cmd.walk_restart = 1'b1;
                        n_phase = bfng_pkg::MODE_DETECT;
                    end
                end else begin
                    n_state = S_QRD;
                end
            end
            S_EDGE: begin
                o_cmd.dist_rd = 1'b1;
                n_state = S_DIST;
            end
            S_DIST: begin
                o_cmd.cand = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = S_FETCH;
            end
            S_QRD: begin
                if (i_st.q_empty) begin
                    n_state = S_TRD;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state = S_QTAKE;
                end
            end
            S_QTAKE: begin
                o_cmd.q_take = 1'b1;
                n_phase = bfng_pkg::MODE_SPREAD;
                n_state = S_FETCH;
            end
            S_TRD: begin
                o_cmd.t_rd = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= bfng_pkg::MODE_RELAX;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end
endmodule

// ----- design/bfng_dp.sv -----
// bfng_dp: configuration, edge store, distance tables, marks, work queue
// and result register; depends on bfng_pkg, bfng_if and bfng_ram
module bfng_dp #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bfng_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [bfng_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    bfng_edge_if.sink                           i_edge,
    bfng_res_if.source                          o_res,
    input  bfng_pkg::t_cmd                      i_cmd,
    output bfng_pkg::t_status                   o_st
);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VB = bfng_pkg::VERT_BITS;
    localparam int CB = bfng_pkg::COST_BITS;
    localparam int WW = bfng_pkg::WIDE_WEIGHT;
    localparam int QB = bfng_pkg::QCOUNT_BITS;
    localparam int NV = bfng_pkg::VERT_SLOTS;

    function automatic logic f_in_range(input logic [VB-1:0] v, input logic [VB-1:0] vc);
        f_in_range = (v != '0) && (v <= vc) && (32'(v) < MAX_VERTICES);
    endfunction

    function automatic logic [WW-1:0] f_sext(input logic [bfng_pkg::RAW_WEIGHT_BITS-1:0] raw);
        logic [WW-1:0] wide;
        logic [WW-1:0] res;
        wide = WW'(raw);
        for (int i = 0; i < WW; i++) begin
            res[i] = (i < WEIGHT_BITS) ? wide[i] : wide[WEIGHT_BITS-1];
        end
        f_sext = res;
    endfunction

    logic [VB-1:0] r_vc, r_src, r_tgt;
    logic [CW-1:0] r_count, r_k;
    logic          r_drop;
    logic [VB-1:0] r_round;
    logic          r_changed;
    logic [VB-1:0] r_clr;
    logic [QB-1:0] r_head, r_tail;
    logic [VB-1:0] r_u, r_efrom, r_eto;
    logic [WW-1:0] r_ew;
    logic [CB-1:0] r_cand, r_dto;
    logic          r_rfrom, r_rto, r_tto;
    logic          r_out_valid, r_out_na, r_out_drop;
    logic [CB-1:0] r_out_cost;

    logic                          accept, store_full;
    logic [bfng_pkg::EDGE_BITS-1:0] e_rd;
    logic [CB:0]                   da_rd, db_rd;
    logic [VB-1:0]                 q_rd;
    logic                          d_we;
    logic [VB-1:0]                 d_waddr, da_raddr;
    logic [CB:0]                   d_wdata;
    logic                          src_slot;
    logic                          t_we, t_wdata, taint_rd;
    logic [VB-1:0]                 t_waddr, t_raddr;
    logic signed [WW:0]            sum;
    logic                          ovf;
    logic [CB-1:0]                 sat;
    logic                          edge_ok, relax_ok, push, na;

    assign i_edge.ready = i_cmd.load_en;
    assign accept       = i_edge.valid & i_cmd.load_en;
    assign store_full   = (r_count == CW'(MAX_EDGES));

    bfng_ram #(.WIDTH(bfng_pkg::EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (accept & ~store_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_edge.from_vertex, i_edge.to_vertex, i_edge.edge_weight}),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (e_rd)
    );

    // distance words carry a reach bit on top; the clearing pass sets only the source
    assign src_slot = (r_clr == r_src) && f_in_range(r_src, r_vc);
    assign d_we     = i_cmd.init | (i_cmd.cmp & (i_cmd.mode == bfng_pkg::MODE_RELAX) & relax_ok);
    assign d_waddr  = i_cmd.init ? r_clr : r_eto;
    assign d_wdata  = i_cmd.init ? {src_slot, {CB{1'b0}}} : {1'b1, r_cand};
    assign da_raddr = i_cmd.t_rd ? r_tgt : e_rd[2*VB+bfng_pkg::RAW_WEIGHT_BITS-1 -: VB];

    // two copies so the from and to distances come out in the same cycle
    bfng_ram #(.WIDTH(CB + 1), .DEPTH(NV)) u_dist_a (
        .i_clk (i_clk), .i_we (d_we), .i_waddr (d_waddr), .i_wdata (d_wdata),
        .i_re (i_cmd.dist_rd | i_cmd.t_rd), .i_raddr (da_raddr), .o_rdata (da_rd)
    );
    bfng_ram #(.WIDTH(CB + 1), .DEPTH(NV)) u_dist_b (
        .i_clk (i_clk), .i_we (d_we), .i_waddr (d_waddr), .i_wdata (d_wdata),
        .i_re (i_cmd.dist_rd), .i_raddr (e_rd[VB+bfng_pkg::RAW_WEIGHT_BITS-1 -: VB]),
        .o_rdata (db_rd)
    );

    // mark bits, cleared by the same pass
    assign t_we    = i_cmd.init | push;
    assign t_waddr = i_cmd.init ? r_clr : r_eto;
    assign t_wdata = ~i_cmd.init;
    assign t_raddr = i_cmd.t_rd ? r_tgt : e_rd[VB+bfng_pkg::RAW_WEIGHT_BITS-1 -: VB];

    bfng_ram #(.WIDTH(1), .DEPTH(NV)) u_taint (
        .i_clk (i_clk), .i_we (t_we), .i_waddr (t_waddr), .i_wdata (t_wdata),
        .i_re (i_cmd.dist_rd | i_cmd.t_rd), .i_raddr (t_raddr), .o_rdata (taint_rd)
    );

    bfng_ram #(.WIDTH(VB), .DEPTH(NV)) u_queue (
        .i_clk (i_clk), .i_we (push), .i_waddr (r_tail[VB-1:0]), .i_wdata (r_eto),
        .i_re (i_cmd.q_rd), .i_raddr (r_head[VB-1:0]), .o_rdata (q_rd)
    );

    // candidate cost, saturated to the result range
    assign sum = $signed({{(WW-CB+1){da_rd[CB-1]}}, da_rd[CB-1:0]})
                 + $signed({r_ew[WW-1], r_ew});
    assign ovf = !((&sum[WW:CB-1]) || !(|sum[WW:CB-1]));
    assign sat = ovf ? (sum[WW] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}})
                     : sum[CB-1:0];

    assign edge_ok  = f_in_range(r_efrom, r_vc) && f_in_range(r_eto, r_vc);
    assign relax_ok = edge_ok && r_rfrom
                      && (!r_rto || ($signed(r_cand) < $signed(r_dto)));
    assign push = i_cmd.cmp && !r_tto
                  && (((i_cmd.mode == bfng_pkg::MODE_DETECT) && relax_ok)
                      || ((i_cmd.mode == bfng_pkg::MODE_SPREAD) && edge_ok && (r_efrom == r_u)));
    assign na = !f_in_range(r_tgt, r_vc) || !da_rd[CB] || taint_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= bfng_pkg::RESET_VERTEX_COUNT;
            r_src       <= bfng_pkg::RESET_SOURCE;
            r_tgt       <= bfng_pkg::RESET_TARGET;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_k         <= '0;
            r_round     <= '0;
            r_changed   <= 1'b0;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfng_pkg::CFG_VERTEX_COUNT: r_vc  <= i_cfg_data;
                    bfng_pkg::CFG_SOURCE:       r_src <= i_cfg_data;
                    bfng_pkg::CFG_TARGET:       r_tgt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (store_full) r_drop <= 1'b1;
                else            r_count <= r_count + CW'(1);
            end
            if (i_cmd.init) begin
                r_clr     <= r_clr + VB'(1);
                r_k       <= '0;
                r_round   <= '0;
                r_changed <= 1'b0;
                r_head    <= '0;
                r_tail    <= '0;
            end
            if (i_cmd.round_next) begin
                r_round   <= r_round + VB'(1);
                r_changed <= 1'b0;
                r_k       <= '0;
            end
            if (i_cmd.walk_restart || i_cmd.q_take) r_k <= '0;
            if (i_cmd.q_take) begin
                r_u    <= q_rd;
                r_head <= r_head + QB'(1);
            end
            if (i_cmd.cmp) begin
                r_k <= r_k + CW'(1);
                if ((i_cmd.mode == bfng_pkg::MODE_RELAX) && relax_ok) begin
                    r_changed <= 1'b1;
                end
                if (push) begin
                    r_tail <= r_tail + QB'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_drop      <= 1'b0;
                r_k         <= '0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_rd) begin
            r_efrom <= e_rd[2*VB+bfng_pkg::RAW_WEIGHT_BITS-1 -: VB];
            r_eto   <= e_rd[VB+bfng_pkg::RAW_WEIGHT_BITS-1 -: VB];
            r_ew    <= f_sext(e_rd[bfng_pkg::RAW_WEIGHT_BITS-1:0]);
        end
        if (i_cmd.cand) begin
            r_cand  <= sat;
            r_dto   <= db_rd[CB-1:0];
            r_rfrom <= da_rd[CB];
            r_rto   <= db_rd[CB];
            r_tto   <= taint_rd;
        end
        if (i_cmd.emit) begin
            r_out_na   <= na;
            r_out_cost <= na ? '0 : da_rd[CB-1:0];
            r_out_drop <= r_drop;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.path_cost     = r_out_cost;
    assign o_res.no_answer     = r_out_na;
    assign o_res.edges_dropped = r_out_drop;

    assign o_st.start       = accept & i_edge.last_edge;
    assign o_st.clr_last    = (r_clr == '1);
    assign o_st.walk_end    = (r_k == r_count);
    assign o_st.changed     = r_changed;
    assign o_st.more_rounds = ({1'b0, r_round} + 9'd2) < {1'b0, r_vc};
    assign o_st.vc_gt1      = (r_vc > VB'(1));
    assign o_st.q_empty     = (r_head == r_tail);
    assign o_st.out_free    = !r_out_valid || o_res.ready;

    a_na_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_na |-> r_out_cost == '0)
        else $error("cost not zero with no answer");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= QB'(NV - 1))
        else $error("more marks queued than vertices");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_count)
        else $error("edge walk beyond stored edges");
endmodule

// ----- dv/bellman_ford_negative_cycle_guard_tb.sv -----
// bellman_ford_negative_cycle_guard_tb: self-checking bench for the shortest-path block
// depends on bfng_pkg, bfng_if and the bellman_ford_negative_cycle_guard rtl
module bellman_ford_negative_cycle_guard_tb;

    localparam int MAX_EDGES_TB = 1024;
    localparam longint COST_LO  = -8388608;
    localparam longint COST_HI  = 8388607;

    typedef struct packed {
        logic [7:0]  from_v;
        logic [7:0]  to_v;
        logic [15:0] weight;
        logic        last;
    } t_edge;

    typedef struct packed {
        logic signed [23:0] cost;
        logic               no_ans;
        logic               dropped;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bfng_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [bfng_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    bfng_edge_if edge_ch ();
    bfng_res_if  res_ch ();

    bellman_ford_negative_cycle_guard i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_ch.sink),
        .o_res      (res_ch.source)
    );

    // predictor copy of the registers and the edge store
    logic [7:0] vcount_m, src_m, tgt_m;
    logic [7:0]  store_from [MAX_EDGES_TB];
    logic [7:0]  store_to   [MAX_EDGES_TB];
    logic [15:0] store_w    [MAX_EDGES_TB];
    int          store_cnt;
    bit          drop_m;

    t_edge   pending_edges [$];
    t_answer expected_answers [$];
    int      error_count;
    bit      hold_sink;      // long receiver hold-off
    bit      hold_req;
    bit      gaps_on;
    bit      edge_taken;     // offer transferred at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial begin
        wait (hold_req);
        hold_sink = 1;
        repeat (20000) @(posedge i_clk);
        hold_sink = 0;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    task automatic add_edge(input t_edge e);
        pending_edges.insert(pending_edges.size(), e);
    endtask

    function automatic bit vert_ok(input logic [7:0] v);
        return v >= 1 && v <= vcount_m;
    endfunction

    // full shortest path solve with negative-cycle taint, on the stored edges
    function automatic t_answer solve_graph();
        longint cost_tab [256];
        bit reach [256];
        bit taint [256];
        int fifo [$];
        t_answer a;
        bit changed;
        longint c;
        int u;
        for (int v = 0; v < 256; v++) begin
            cost_tab[v] = 0; reach[v] = 0; taint[v] = 0;
        end
        if (vert_ok(src_m)) reach[src_m] = 1;
        for (int r = 0; r + 1 < vcount_m; r++) begin
            changed = 0;
            for (int k = 0; k < store_cnt; k++) begin
                if (vert_ok(store_from[k]) && vert_ok(store_to[k]) && reach[store_from[k]]) begin
                    c = cost_tab[store_from[k]] + longint'($signed(store_w[k]));
                    if (c < COST_LO) c = COST_LO;
                    if (c > COST_HI) c = COST_HI;
                    if (!reach[store_to[k]] || c < cost_tab[store_to[k]]) begin
                        cost_tab[store_to[k]] = c;
                        reach[store_to[k]] = 1;
                        changed = 1;
                    end
                end
            end
            if (!changed) break;
        end
        // edges still relaxable mark their end vertex
        for (int k = 0; k < store_cnt; k++) begin
            if (vert_ok(store_from[k]) && vert_ok(store_to[k]) && reach[store_from[k]]) begin
                c = cost_tab[store_from[k]] + longint'($signed(store_w[k]));
                if (c < COST_LO) c = COST_LO;
                if (c > COST_HI) c = COST_HI;
                if ((!reach[store_to[k]] || c < cost_tab[store_to[k]])
                    && !taint[store_to[k]]) begin
                    taint[store_to[k]] = 1;
                    fifo.insert(fifo.size(), store_to[k]);
                end
            end
        end
        // spread marks to everything reachable
        while (fifo.size() > 0) begin
            u = fifo.pop_front();
            for (int k = 0; k < store_cnt; k++)
                if (vert_ok(store_from[k]) && vert_ok(store_to[k]) &&
                    store_from[k] == u && !taint[store_to[k]]) begin
                    taint[store_to[k]] = 1;
                    fifo.insert(fifo.size(), store_to[k]);
                end
        end
        if (!vert_ok(tgt_m) || !reach[tgt_m] || taint[tgt_m]) begin
            a.cost = '0; a.no_ans = 1'b1;
        end else begin
            a.cost = cost_tab[tgt_m][23:0]; a.no_ans = 1'b0;
        end
        a.dropped = drop_m;
        return a;
    endfunction

    // driver: bursts and gaps, change on falling edge
    int gap_left, burst_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            edge_ch.valid <= 1'b0;
        end else if (edge_ch.valid && !edge_taken) begin
            // hold the offer
        end else if (pending_edges.size() == 0 || gap_left > 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            edge_ch.valid <= 1'b0;
        end else begin
            edge_ch.valid       <= 1'b1;
            edge_ch.from_vertex <= pending_edges[0].from_v;
            edge_ch.to_vertex   <= pending_edges[0].to_v;
            edge_ch.edge_weight <= pending_edges[0].weight;
            edge_ch.last_edge   <= pending_edges[0].last;
            void'(pending_edges.pop_front());
            if (burst_left > 0) burst_left <= burst_left - 1;
            else if (gaps_on) begin
                burst_left <= $urandom_range(12, 0);
                gap_left   <= $urandom_range(5, 1);
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) res_ch.ready <= 1'b0;
        else res_ch.ready <= gaps_on ? ($urandom_range(3, 0) != 0) : 1'b1;
    end

    // monitor: predict on edge transfer, check on result transfer
    t_answer got, want;
    always @(posedge i_clk) begin
        edge_taken = i_rst_n && edge_ch.valid && edge_ch.ready;
        if (edge_taken) begin
            if (store_cnt < MAX_EDGES_TB) begin
                store_from[store_cnt] = edge_ch.from_vertex;
                store_to[store_cnt]   = edge_ch.to_vertex;
                store_w[store_cnt]    = edge_ch.edge_weight;
                store_cnt++;
            end else begin
                drop_m = 1;
            end
            if (edge_ch.last_edge) begin
                expected_answers.insert(expected_answers.size(), solve_graph());
                store_cnt = 0;
                drop_m = 0;
            end
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.cost = res_ch.path_cost;
            got.no_ans = res_ch.no_answer;
            got.dropped = res_ch.edges_dropped;
            if (expected_answers.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                want = expected_answers.pop_front();
                if (got.cost != want.cost)
                    report($sformatf("path_cost %0d want %0d", got.cost, want.cost));
                if (got.no_ans != want.no_ans)
                    report($sformatf("no_answer %0b want %0b", got.no_ans, want.no_ans));
                if (got.dropped != want.dropped)
                    report($sformatf("edges_dropped %0b want %0b", got.dropped, want.dropped));
            end
        end
    end

    function automatic t_edge mk(input int f, input int t, input int w, input bit l);
        t_edge e;
        e.from_v = f[7:0]; e.to_v = t[7:0]; e.weight = w[15:0]; e.last = l;
        return e;
    endfunction

    // one graph of random content over a small vertex set
    task automatic queue_graph(input int n_edges, input int vmax);
        int f, t, w;
        for (int i = 0; i < n_edges; i++) begin
            f = $urandom_range(vmax, 1);
            t = $urandom_range(vmax, 1);
            case ($urandom_range(9, 0))
                0: w = -32768;
                1: w = 32767;
                2, 3: w = $urandom_range(65535, 0) - 32768;
                default: w = $urandom_range(40, 0) - 8;
            endcase
            if ($urandom_range(19, 0) == 0) f = $urandom_range(255, 0);
            if ($urandom_range(19, 0) == 0) t = $urandom_range(255, 0);
            add_edge(mk(f, t, w, i == n_edges - 1));
        end
    endtask

    task automatic drain();
        while (pending_edges.size() > 0 || edge_ch.valid) @(posedge i_clk);
        while (expected_answers.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bfng_pkg::CFG_IDX_BITS-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val[7:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int vc, input int s, input int t);
        write_reg(bfng_pkg::CFG_VERTEX_COUNT, vc);
        vcount_m = vc[7:0];
        write_reg(bfng_pkg::CFG_SOURCE, s);
        src_m = s[7:0];
        write_reg(bfng_pkg::CFG_TARGET, t);
        tgt_m = t[7:0];
    endtask

    int n_items, vc;
    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        edge_ch.valid = 1'b0; edge_ch.from_vertex = '0; edge_ch.to_vertex = '0;
        edge_ch.edge_weight = '0; edge_ch.last_edge = 1'b0; res_ch.ready = 1'b0;
        vcount_m = bfng_pkg::RESET_VERTEX_COUNT;
        src_m = bfng_pkg::RESET_SOURCE;
        tgt_m = bfng_pkg::RESET_TARGET;
        store_cnt = 0; drop_m = 0; error_count = 0; hold_sink = 0; gaps_on = 0;
        gap_left = 0; burst_left = 0; edge_taken = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: reset settings, a chain with extremes, a negative cycle, edge vertex counts
        add_edge(mk(1, 1, 0, 1));
        drain();
        set_regs(4, 1, 3);
        add_edge(mk(1, 2, 32767, 0));
        add_edge(mk(2, 3, 32767, 0));
        add_edge(mk(0, 3, -5, 0));     // out-of-range start
        add_edge(mk(255, 255, -1, 1));
        drain();
        add_edge(mk(1, 2, -32768, 0));
        add_edge(mk(2, 3, -32768, 0));
        add_edge(mk(3, 2, -32768, 0)); // negative cycle taints 3
        add_edge(mk(3, 4, 7, 1));
        drain();
        set_regs(255, 255, 254);
        add_edge(mk(255, 254, -3, 0));
        add_edge(mk(170, 85, 21845, 1));
        drain();
        set_regs(1, 1, 1);                            // no rounds at all
        add_edge(mk(1, 1, -1, 1));
        drain();
        set_regs(0, 0, 9);                            // zero count, bad source
        add_edge(mk(0, 0, 0, 1));
        drain();

        // overflow: more edges than the store holds, last one dropped too
        set_regs(8, 2, 5);
        queue_graph(MAX_EDGES_TB + 3, 8);
        drain();

        // random graphs with bursts and stalls
        gaps_on = 1;
        n_items = 0;
        while (n_items < 510) begin
            vc = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 1) : $urandom_range(10, 2);
            set_regs(vc, $urandom_range(vc + 1, 1), $urandom_range(vc + 1, 1));
            for (int g = 0; g < 6; g++) begin
                int ne;
                ne = $urandom_range(16, 1);
                queue_graph(ne, vc < 12 ? vc + 1 : 12);
                n_items += ne;
            end
            if (n_items > 200 && n_items < 320) begin
                // receiver holds off while edges keep coming
                hold_req = 1;
            end
            drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
